@@ rtl/core/ucw_pkg.sv @@
// ucw_pkg: shared types, constants and range tables for the column width core.
// No dependencies.
`default_nettype none
package ucw_pkg;

  localparam int unsigned CpW = 21;
  localparam int unsigned WidthW = 3;

  localparam int unsigned NumBmp = 129;
  localparam int unsigned NumP1 = 10;
  localparam int unsigned NumWide = 11;

  typedef logic [CpW-1:0] cp_t;
  typedef logic signed [WidthW-1:0] width_t;

  localparam width_t WidthCtrl = -3'sd1;
  localparam width_t WidthZero = 3'sd0;
  localparam width_t WidthNarrow = 3'sd1;
  localparam width_t WidthWide = 3'sd2;

  // Early classification carried between stages
  typedef enum logic [1:0] {
    CLS_NONE,
    CLS_NUL,
    CLS_CTRL,
    CLS_LOW
  } cls_t;

  typedef struct packed {
    cls_t cls;
    logic zw_fixed;
    logic wide_hit;
  } flags_t;

  typedef logic [2*CpW-1:0] span_t;

  localparam span_t BMP_TAB [NumBmp] = '{
    {21'h0300,21'h036F},{21'h0483,21'h0486},{21'h0488,21'h0489},{21'h0591,21'h05BD},
    {21'h05BF,21'h05BF},{21'h05C1,21'h05C2},{21'h05C4,21'h05C5},{21'h05C7,21'h05C7},
    {21'h0600,21'h0603},{21'h0610,21'h0615},{21'h064B,21'h065E},{21'h0670,21'h0670},
    {21'h06D6,21'h06E4},{21'h06E7,21'h06E8},{21'h06EA,21'h06ED},{21'h070F,21'h070F},
    {21'h0711,21'h0711},{21'h0730,21'h074A},{21'h07A6,21'h07B0},{21'h07EB,21'h07F3},
    {21'h0901,21'h0902},{21'h093C,21'h093C},{21'h0941,21'h0948},{21'h094D,21'h094D},
    {21'h0951,21'h0954},{21'h0962,21'h0963},{21'h0981,21'h0981},{21'h09BC,21'h09BC},
    {21'h09C1,21'h09C4},{21'h09CD,21'h09CD},{21'h09E2,21'h09E3},{21'h0A01,21'h0A02},
    {21'h0A3C,21'h0A3C},{21'h0A41,21'h0A42},{21'h0A47,21'h0A48},{21'h0A4B,21'h0A4D},
    {21'h0A70,21'h0A71},{21'h0A81,21'h0A82},{21'h0ABC,21'h0ABC},{21'h0AC1,21'h0AC5},
    {21'h0AC7,21'h0AC8},{21'h0ACD,21'h0ACD},{21'h0AE2,21'h0AE3},{21'h0B01,21'h0B01},
    {21'h0B3C,21'h0B3C},{21'h0B3F,21'h0B3F},{21'h0B41,21'h0B43},{21'h0B4D,21'h0B4D},
    {21'h0B56,21'h0B56},{21'h0B82,21'h0B82},{21'h0BC0,21'h0BC0},{21'h0BCD,21'h0BCD},
    {21'h0C3E,21'h0C40},{21'h0C46,21'h0C48},{21'h0C4A,21'h0C4D},{21'h0C55,21'h0C56},
    {21'h0CBC,21'h0CBC},{21'h0CBF,21'h0CBF},{21'h0CC6,21'h0CC6},{21'h0CCC,21'h0CCD},
    {21'h0CE2,21'h0CE3},{21'h0D41,21'h0D43},{21'h0D4D,21'h0D4D},{21'h0DCA,21'h0DCA},
    {21'h0DD2,21'h0DD4},{21'h0DD6,21'h0DD6},{21'h0E31,21'h0E31},{21'h0E34,21'h0E3A},
    {21'h0E47,21'h0E4E},{21'h0EB1,21'h0EB1},{21'h0EB4,21'h0EB9},{21'h0EBB,21'h0EBC},
    {21'h0EC8,21'h0ECD},{21'h0F18,21'h0F19},{21'h0F35,21'h0F35},{21'h0F37,21'h0F37},
    {21'h0F39,21'h0F39},{21'h0F71,21'h0F7E},{21'h0F80,21'h0F84},{21'h0F86,21'h0F87},
    {21'h0FC6,21'h0FC6},{21'h0F90,21'h0F97},{21'h0F99,21'h0FBC},{21'h102D,21'h1030},
    {21'h1032,21'h1032},{21'h1036,21'h1037},{21'h1039,21'h1039},{21'h1058,21'h1059},
    {21'h1160,21'h11FF},{21'h135F,21'h135F},{21'h1712,21'h1714},{21'h1732,21'h1734},
    {21'h1752,21'h1753},{21'h1772,21'h1773},{21'h17B4,21'h17B5},{21'h17B7,21'h17BD},
    {21'h17C6,21'h17C6},{21'h17C9,21'h17D3},{21'h17DD,21'h17DD},{21'h180B,21'h180D},
    {21'h18A9,21'h18A9},{21'h1920,21'h1922},{21'h1927,21'h1928},{21'h1932,21'h1932},
    {21'h1939,21'h193B},{21'h1A17,21'h1A18},{21'h1B00,21'h1B03},{21'h1B34,21'h1B34},
    {21'h1B36,21'h1B3A},{21'h1B3C,21'h1B3C},{21'h1B42,21'h1B42},{21'h1B6B,21'h1B73},
    {21'h1DC0,21'h1DCA},{21'h1DFE,21'h1DFF},{21'h200B,21'h200F},{21'h202A,21'h202E},
    {21'h2060,21'h2063},{21'h206A,21'h206F},{21'h20D0,21'h20EF},{21'h302A,21'h302F},
    {21'h3099,21'h309A},{21'hA806,21'hA806},{21'hA80B,21'hA80B},{21'hA825,21'hA826},
    {21'hFB1E,21'hFB1E},{21'hFE00,21'hFE0F},{21'hFE20,21'hFE23},{21'hFEFF,21'hFEFF},
    {21'hFFF9,21'hFFFB}
  };

  localparam span_t P1_TAB [NumP1] = '{
    {21'h10A01,21'h10A03},{21'h10A05,21'h10A06},{21'h10A0C,21'h10A0F},
    {21'h10A38,21'h10A3A},{21'h10A3F,21'h10A3F},{21'h1D167,21'h1D169},
    {21'h1D173,21'h1D182},{21'h1D185,21'h1D18B},{21'h1D1AA,21'h1D1AD},
    {21'h1D242,21'h1D244}
  };

  localparam span_t WIDE_TAB [NumWide] = '{
    {21'h1100,21'h115F},{21'h2329,21'h232A},{21'h2E80,21'hA4CF},{21'hAC00,21'hD7A3},
    {21'hF900,21'hFAFF},{21'hFE10,21'hFE19},{21'hFE30,21'hFE6F},{21'hFF00,21'hFF60},
    {21'hFFE0,21'hFFE6},{21'h20000,21'h2FFFD},{21'h30000,21'h3FFFD}
  };

endpackage
`default_nettype wire

@@ rtl/core/ucw_stage.sv @@
// ucw_stage: one pipeline register stage with valid/stall and a payload.
// Uses nothing from the package.
`default_nettype none
module ucw_stage #(
  parameter int unsigned DataW = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             up_valid,
  output logic                  up_stall,
  input  wire logic [DataW-1:0] up_data,
  output logic                  dn_valid,
  input  wire logic             dn_stall,
  output logic [DataW-1:0]      dn_data
);

  // Register may load when empty or when its item leaves this cycle
  assign up_stall = dn_valid && dn_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (!up_stall) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall && up_valid) begin
      dn_data <= up_data;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/ucw_match.sv @@
// ucw_match: combinational range-comparator banks; the BMP table is split into halves
// whose hits are reported separately. Depends on ucw_pkg.
`default_nettype none
module ucw_match (
  input  wire ucw_pkg::cp_t cp,
  output logic [3:0]        hits
);

  localparam int unsigned Half = ucw_pkg::NumBmp / 2;

  logic bmp_a, bmp_b, p1, wide;

  always_comb begin
    bmp_a = 1'b0;
    bmp_b = 1'b0;
    p1 = 1'b0;
    wide = 1'b0;
    for (int i = 0; i < int'(ucw_pkg::NumBmp); i++) begin
      if (cp >= ucw_pkg::BMP_TAB[i][2*ucw_pkg::CpW-1:ucw_pkg::CpW] &&
          cp <= ucw_pkg::BMP_TAB[i][ucw_pkg::CpW-1:0]) begin
        if (i < int'(Half)) bmp_a = 1'b1;
        else bmp_b = 1'b1;
      end
    end
    for (int i = 0; i < int'(ucw_pkg::NumP1); i++) begin
      if (cp >= ucw_pkg::P1_TAB[i][2*ucw_pkg::CpW-1:ucw_pkg::CpW] &&
          cp <= ucw_pkg::P1_TAB[i][ucw_pkg::CpW-1:0]) p1 = 1'b1;
    end
    for (int i = 0; i < int'(ucw_pkg::NumWide); i++) begin
      if (cp >= ucw_pkg::WIDE_TAB[i][2*ucw_pkg::CpW-1:ucw_pkg::CpW] &&
          cp <= ucw_pkg::WIDE_TAB[i][ucw_pkg::CpW-1:0]) wide = 1'b1;
    end
  end

  assign hits = {bmp_a, bmp_b, p1, wide};

endmodule
`default_nettype wire

@@ rtl/core/unicode_column_width_core.sv @@
// unicode_column_width_core: top level of the terminal column width classifier.
// Depends on ucw_pkg, ucw_stage and ucw_match.
//
// Takes one code point per cycle and returns its terminal cell width
// (-1 control, 0 zero-width, 1 narrow, 2 wide). Three register stages:
// decode of the low special codes, table range compare, final priority
// select; throughput is one item per clock when out stall is low, and a
// stall holds every stage without loss.
`default_nettype none
module unicode_column_width_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire ucw_pkg::cp_t        code_point,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ucw_pkg::width_t          column_width
);

  localparam int unsigned S1W = ucw_pkg::CpW + $bits(ucw_pkg::cls_t) + 1;
  localparam int unsigned S2W = $bits(ucw_pkg::cls_t) + 1 + 4;

  // stage 1: special low codes, the fixed plane-14 ranges and U+303F
  ucw_pkg::cls_t cls0;
  logic          zw_fix0;
  always_comb begin
    if (code_point == '0) cls0 = ucw_pkg::CLS_NUL;
    else if (code_point < 21'h20 || (code_point >= 21'h7F && code_point <= 21'h9F))
      cls0 = ucw_pkg::CLS_CTRL;
    else if (code_point < 21'h0300) cls0 = ucw_pkg::CLS_LOW;
    else cls0 = ucw_pkg::CLS_NONE;
    zw_fix0 = code_point == 21'hE0001 ||
              (code_point >= 21'hE0020 && code_point <= 21'hE007F) ||
              (code_point >= 21'hE0100 && code_point <= 21'hE01EF) ||
              code_point == 21'h303F;
  end

  logic            v1, st1;
  logic [S1W-1:0]  d1;
  ucw_stage #(.DataW(S1W)) u_s1 (
    .clk, .rst, .up_valid(in_valid), .up_stall(in_stall),
    .up_data({code_point, cls0, zw_fix0}),
    .dn_valid(v1), .dn_stall(st1), .dn_data(d1)
  );

  ucw_pkg::cp_t  cp1;
  ucw_pkg::cls_t cls1;
  logic          fix1;
  assign {cp1, cls1, fix1} = d1;

  // U+303F is carried in the fixed flag but means "not wide" rather than zero
  logic is303f1;
  assign is303f1 = cp1 == 21'h303F;

  logic [3:0] hits1;
  ucw_match u_match (.cp(cp1), .hits(hits1));

  logic            v2, st2;
  logic [S2W-1:0]  d2;
  ucw_stage #(.DataW(S2W)) u_s2 (
    .clk, .rst, .up_valid(v1), .up_stall(st1),
    .up_data({cls1, fix1 && !is303f1, hits1[3:1], hits1[0] && !is303f1}),
    .dn_valid(v2), .dn_stall(st2), .dn_data(d2)
  );

  ucw_pkg::cls_t cls2;
  logic          fix2, ba2, bb2, p12, wd2;
  ucw_pkg::width_t w2;
  assign {cls2, fix2, ba2, bb2, p12, wd2} = d2;

  always_comb begin
    case (cls2)
      ucw_pkg::CLS_NUL:  w2 = ucw_pkg::WidthZero;
      ucw_pkg::CLS_CTRL: w2 = ucw_pkg::WidthCtrl;
      ucw_pkg::CLS_LOW:  w2 = ucw_pkg::WidthNarrow;
      default: begin
        if (fix2 || ba2 || bb2 || p12) w2 = ucw_pkg::WidthZero;
        else if (wd2) w2 = ucw_pkg::WidthWide;
        else w2 = ucw_pkg::WidthNarrow;
      end
    endcase
  end

  ucw_stage #(.DataW(ucw_pkg::WidthW)) u_s3 (
    .clk, .rst, .up_valid(v2), .up_stall(st2), .up_data(w2),
    .dn_valid(out_valid), .dn_stall(out_stall), .dn_data(column_width)
  );

endmodule
`default_nettype wire

@@ rtl/core/ucw_checker.sv @@
// ucw_checker: port-level assertions for unicode_column_width_core, with bind.
// Depends on ucw_pkg.
`default_nettype none
module ucw_checker (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            in_valid,
  input wire logic            in_stall,
  input wire ucw_pkg::cp_t    code_point,
  input wire logic            out_valid,
  input wire logic            out_stall,
  input wire ucw_pkg::width_t column_width
);

  // width is always one of the four legal codes
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> column_width != -3'sd2 && column_width != -3'sd3 &&
                  column_width != -3'sd4 && column_width != 3'sd3)
    else $error("illegal width");

  // a held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(column_width))
    else $error("result changed under stall");

  // input side never stalls without downstream backpressure
  a_nostall: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("spurious input stall");

  // a code point of zero with a free pipe comes out with width zero
  a_nul: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && code_point == '0 && !out_stall ##1 !out_stall ##1 !out_stall
    |=> out_valid && column_width == ucw_pkg::WidthZero)
    else $error("NUL width wrong");

endmodule

bind unicode_column_width_core ucw_checker u_ucw_checker (.*);
`default_nettype wire

@@ verif/tb_unicode_column_width_core.sv @@
// Testbench for unicode_column_width_core: drives code points, predicts cell widths
// from its own range tables and checks every result in order.
// Depends on ucw_pkg and the core RTL.
`default_nettype none

class width_scoreboard;
  ucw_pkg::width_t pending_widths[$];
  int errors;

  function new();
    errors = 0;
  endfunction

  static function bit in_span(int unsigned cp, int unsigned lo, int unsigned hi);
    return cp >= lo && cp <= hi;
  endfunction

  static function ucw_pkg::width_t measure_cells(ucw_pkg::cp_t cp);
    int unsigned c;
    int unsigned zw[258];
    int unsigned p1[20];
    int unsigned wd[22];
    c = cp;
    zw = '{
      'h0300,'h036F,'h0483,'h0486,'h0488,'h0489,'h0591,'h05BD,'h05BF,'h05BF,
      'h05C1,'h05C2,'h05C4,'h05C5,'h05C7,'h05C7,'h0600,'h0603,'h0610,'h0615,
      'h064B,'h065E,'h0670,'h0670,'h06D6,'h06E4,'h06E7,'h06E8,'h06EA,'h06ED,
      'h070F,'h070F,'h0711,'h0711,'h0730,'h074A,'h07A6,'h07B0,'h07EB,'h07F3,
      'h0901,'h0902,'h093C,'h093C,'h0941,'h0948,'h094D,'h094D,'h0951,'h0954,
      'h0962,'h0963,'h0981,'h0981,'h09BC,'h09BC,'h09C1,'h09C4,'h09CD,'h09CD,
      'h09E2,'h09E3,'h0A01,'h0A02,'h0A3C,'h0A3C,'h0A41,'h0A42,'h0A47,'h0A48,
      'h0A4B,'h0A4D,'h0A70,'h0A71,'h0A81,'h0A82,'h0ABC,'h0ABC,'h0AC1,'h0AC5,
      'h0AC7,'h0AC8,'h0ACD,'h0ACD,'h0AE2,'h0AE3,'h0B01,'h0B01,'h0B3C,'h0B3C,
      'h0B3F,'h0B3F,'h0B41,'h0B43,'h0B4D,'h0B4D,'h0B56,'h0B56,'h0B82,'h0B82,
      'h0BC0,'h0BC0,'h0BCD,'h0BCD,'h0C3E,'h0C40,'h0C46,'h0C48,'h0C4A,'h0C4D,
      'h0C55,'h0C56,'h0CBC,'h0CBC,'h0CBF,'h0CBF,'h0CC6,'h0CC6,'h0CCC,'h0CCD,
      'h0CE2,'h0CE3,'h0D41,'h0D43,'h0D4D,'h0D4D,'h0DCA,'h0DCA,'h0DD2,'h0DD4,
      'h0DD6,'h0DD6,'h0E31,'h0E31,'h0E34,'h0E3A,'h0E47,'h0E4E,'h0EB1,'h0EB1,
      'h0EB4,'h0EB9,'h0EBB,'h0EBC,'h0EC8,'h0ECD,'h0F18,'h0F19,'h0F35,'h0F35,
      'h0F37,'h0F37,'h0F39,'h0F39,'h0F71,'h0F7E,'h0F80,'h0F84,'h0F86,'h0F87,
      'h0FC6,'h0FC6,'h0F90,'h0F97,'h0F99,'h0FBC,'h102D,'h1030,'h1032,'h1032,
      'h1036,'h1037,'h1039,'h1039,'h1058,'h1059,'h1160,'h11FF,'h135F,'h135F,
      'h1712,'h1714,'h1732,'h1734,'h1752,'h1753,'h1772,'h1773,'h17B4,'h17B5,
      'h17B7,'h17BD,'h17C6,'h17C6,'h17C9,'h17D3,'h17DD,'h17DD,'h180B,'h180D,
      'h18A9,'h18A9,'h1920,'h1922,'h1927,'h1928,'h1932,'h1932,'h1939,'h193B,
      'h1A17,'h1A18,'h1B00,'h1B03,'h1B34,'h1B34,'h1B36,'h1B3A,'h1B3C,'h1B3C,
      'h1B42,'h1B42,'h1B6B,'h1B73,'h1DC0,'h1DCA,'h1DFE,'h1DFF,'h200B,'h200F,
      'h202A,'h202E,'h2060,'h2063,'h206A,'h206F,'h20D0,'h20EF,'h302A,'h302F,
      'h3099,'h309A,'hA806,'hA806,'hA80B,'hA80B,'hA825,'hA826,'hFB1E,'hFB1E,
      'hFE00,'hFE0F,'hFE20,'hFE23,'hFEFF,'hFEFF,'hFFF9,'hFFFB};
    p1 = '{'h10A01,'h10A03,'h10A05,'h10A06,'h10A0C,'h10A0F,'h10A38,'h10A3A,
           'h10A3F,'h10A3F,'h1D167,'h1D169,'h1D173,'h1D182,'h1D185,'h1D18B,
           'h1D1AA,'h1D1AD,'h1D242,'h1D244};
    wd = '{'h1100,'h115F,'h2329,'h232A,'h2E80,'hA4CF,'hAC00,'hD7A3,'hF900,'hFAFF,
           'hFE10,'hFE19,'hFE30,'hFE6F,'hFF00,'hFF60,'hFFE0,'hFFE6,
           'h20000,'h2FFFD,'h30000,'h3FFFD};
    if (c == 0) return ucw_pkg::WidthZero;
    if (c < 'h20 || in_span(c, 'h7F, 'h9F)) return ucw_pkg::WidthCtrl;
    if (c < 'h300) return ucw_pkg::WidthNarrow;
    for (int i = 0; i < 258; i += 2)
      if (in_span(c, zw[i], zw[i+1])) return ucw_pkg::WidthZero;
    for (int i = 0; i < 20; i += 2)
      if (in_span(c, p1[i], p1[i+1])) return ucw_pkg::WidthZero;
    if (c == 'hE0001 || in_span(c, 'hE0020, 'hE007F) || in_span(c, 'hE0100, 'hE01EF))
      return ucw_pkg::WidthZero;
    if (c != 'h303F)
      for (int i = 0; i < 22; i += 2)
        if (in_span(c, wd[i], wd[i+1])) return ucw_pkg::WidthWide;
    return ucw_pkg::WidthNarrow;
  endfunction

  function void note_code_point(ucw_pkg::cp_t cp);
    pending_widths.push_back(measure_cells(cp));
  endfunction

  task report(string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endtask

  task check_width(ucw_pkg::width_t got);
    ucw_pkg::width_t want;
    if (pending_widths.size() == 0) begin
      report($sformatf("unexpected width %0d", got));
      return;
    end
    want = pending_widths.pop_front();
    if (got !== want) report($sformatf("width got %0d want %0d", got, want));
  endtask
endclass

module tb_unicode_column_width_core;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  ucw_pkg::cp_t code_point = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ucw_pkg::width_t column_width;

  width_scoreboard sb = new();
  bit calm = 1'b0;        // long stretch with no idling on either side
  bit hold_out = 1'b0;    // long receiver hold-off
  bit stim_done = 1'b0;
  int idle_cycles = 0;
  localparam int IdleLimit = 5000;

  unicode_column_width_core i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .code_point(code_point), .out_valid(out_valid), .out_stall(out_stall),
    .column_width(column_width)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Called at a falling edge; leaves valid high after the accepting edge so
  // the next item can follow with no gap.
  task automatic send_item(ucw_pkg::cp_t cp);
    while (!calm && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    code_point <= cp;
    do @(posedge clk); while (in_stall);
    sb.note_code_point(cp);
    @(negedge clk);
  endtask

  function automatic ucw_pkg::cp_t pick_code_point();
    int unsigned sel;
    sel = $urandom_range(9);
    case (sel)
      0: return ucw_pkg::cp_t'($urandom_range(255));
      1: return ucw_pkg::cp_t'($urandom_range('h0300, 'h1200));
      2: return ucw_pkg::cp_t'($urandom_range('h1700, 'h3100));
      3: return ucw_pkg::cp_t'($urandom_range('hA800, 'hFFFF));
      4: return ucw_pkg::cp_t'($urandom_range('h10A00, 'h10A40));
      5: return ucw_pkg::cp_t'($urandom_range('h1D160, 'h1D250));
      6: return ucw_pkg::cp_t'($urandom_range('hE0000, 'hE0200));
      7: return ucw_pkg::cp_t'($urandom_range('h1FFFF, 'h40000));
      default: return ucw_pkg::cp_t'($urandom);
    endcase
  endfunction

  // Receiver: random stall, a calm stretch, and one long hold-off.
  always @(negedge clk) begin
    if (hold_out) out_stall <= 1'b1;
    else out_stall <= !calm && ($urandom_range(99) < 24);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_width(column_width);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit && !stim_done) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    ucw_pkg::cp_t directed[$];
    directed = '{21'h0, 21'h1, 21'h1F, 21'h20, 21'h7E, 21'h7F, 21'h9F, 21'hA0, 21'h2FF,
                 21'h300, 21'h36F, 21'h1100, 21'h115F, 21'h1160, 21'h303F, 21'h3040,
                 21'hFFFB, 21'h10A01, 21'h1D244, 21'hE0001, 21'hE007F, 21'hE01EF,
                 21'h2FFFD, 21'h10FFFF, 21'h1FFFFF};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (directed[i]) send_item(directed[i]);
    for (int n = 0; n < 400; n++) begin
      calm = (n >= 100 && n < 160);
      if (n == 200) begin
        fork
          begin
            hold_out = 1'b1;
            repeat (60) @(negedge clk);
            hold_out = 1'b0;
          end
        join_none
      end
      if (n == 300) begin
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending_widths.size() != 0) @(negedge clk);
      end
      send_item(pick_code_point() | (ucw_pkg::cp_t'($urandom_range(1)) << 20) * (n % 7 == 0));
    end
    in_valid <= 1'b0;
    calm = 1'b0;
    fork
      begin
        while (sb.pending_widths.size() != 0) @(negedge clk);
        repeat (10) @(negedge clk);
      end
      begin
        repeat (IdleLimit) @(negedge clk);
      end
    join_any
    stim_done = 1'b1;
    if (sb.pending_widths.size() != 0) sb.report("expected widths left over");
    if (sb.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
`default_nettype wire

@@ sim.f @@
rtl/core/ucw_pkg.sv
rtl/core/ucw_stage.sv
rtl/core/ucw_match.sv
rtl/core/unicode_column_width_core.sv
rtl/core/ucw_checker.sv
verif/tb_unicode_column_width_core.sv
